// ===== sv/sst_pkg.sv =====
// sorted set table: shared types, constants and command codes
package sst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 6;
  localparam int COUNT_W      = 7;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic               status;
  } res_t;

  // what one cell shows its neighbours
  typedef struct packed {
    logic                      valid;
    logic                      lt;
    logic signed [VALUE_W-1:0] entry;
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } op_t;

endpackage

// ===== sv/sst_cell.sv =====
// sorted set table: one storage cell of the ordered chain
module sst_cell (
  input  logic          clk,
  input  logic          rst,
  input  sst_pkg::op_t  op,
  input  sst_pkg::link_t left,
  input  sst_pkg::link_t right,
  output sst_pkg::link_t self,
  output logic          eq
);
  import sst_pkg::*;

  logic                      valid;
  logic signed [VALUE_W-1:0] entry;
  logic                      lt;

  assign lt   = valid && (entry < op.value);
  assign eq   = valid && (entry == op.value);
  assign self = '{valid: valid, lt: lt, entry: entry};

  // cells below the slot hold, the rest shift by one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.ins && !lt) begin
      valid <= left.lt ? 1'b1 : left.valid;
    end else if (op.rem && !lt) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.ins && !lt) begin
      entry <= left.lt ? op.value : left.entry;
    end else if (op.rem && !lt) begin
      entry <= right.entry;
    end
  end

endmodule

// ===== sv/sorted_set_table.sv =====
// sorted set table: ordered set of distinct signed values held in a chain of cells
// a command is taken into the command register, then its result is registered with done
// throughput: one command per cycle, busy stays low; every cell compares and shifts
// in the same cycle, so the whole chain updates at once
// reset: synchronous, clears all cell valid bits and the count; no clearing pass
module sorted_set_table #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sst_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output sst_pkg::res_t result
);
  import sst_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (PW > POS_W) ? PW : POS_W;
  localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;

  logic                      cmd_valid;
  logic [1:0]                cmd_func;
  logic signed [VALUE_W-1:0] cmd_value;

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  link_t               links [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;
  op_t                 op;
  logic                found;
  logic                full;
  logic                is_add;
  logic                is_rem;
  logic                drop;
  logic [IW-1:0]       pos;
  logic [KW-1:0]       cnt_ext;

  link_t head_link;
  link_t tail_link;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_func  <= cmd.func;
      cmd_value <= cmd.value;
    end
  end

  assign head_link = '{valid: 1'b1, lt: 1'b1, entry: '0};
  assign tail_link = '{valid: 1'b0, lt: 1'b0, entry: '0};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      sst_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .op    (op),
        .left  ((g == 0) ? head_link : links[(g == 0) ? 0 : g - 1]),
        .right ((g == CAPACITY - 1) ? tail_link
                                    : links[(g == CAPACITY - 1) ? g : g + 1]),
        .self  (links[g]),
        .eq    (eq_vec[g])
      );
      assign valid_vec[g] = links[g].valid;
    end
  endgenerate

  assign found  = |eq_vec;
  assign full   = valid_vec[CAPACITY-1];
  assign is_add = cmd_valid && (cmd_func == FUNC_ADD);
  assign is_rem = cmd_valid && (cmd_func == FUNC_REMOVE);
  assign drop   = is_add && !found && full;

  assign op = '{ins: is_add && !found && !full, rem: is_rem && found, value: cmd_value};

  // at most one cell matches, so an or of indices encodes it
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos = pos | (eq_vec[i] ? IW'(i) : IW'(0));
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (op.ins) begin
      cnt_next = cnt + CW'(1);
    end else if (op.rem) begin
      cnt_next = cnt - CW'(1);
    end
  end

  assign cnt_ext = KW'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      result.found    <= found;
      result.position <= pos[POS_W-1:0];
      result.count    <= cnt_ext[COUNT_W-1:0];
      result.status   <= drop;
    end
  end

  a_single_match: assert property (@(posedge clk) disable iff (rst) $onehot0(eq_vec))
    else $error("more than one cell holds the same value");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(cnt))
    else $error("count does not match occupied cells");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |=> done)
    else $error("command gave no result");

  a_drop_absent: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> !result.found)
    else $error("dropped add reported a present value");

endmodule
